### rtl/core/deaa_pkg.sv
// Shared constants, codes and helpers for the double-ended arena allocator.
package deaa_pkg;

  // Pool geometry
  localparam int ALIGN_LOG2  = 7;
  localparam int ALIGNMENT   = 1 << ALIGN_LOG2;
  localparam int STACK_DEPTH = 16;

  // Field and register widths
  localparam int FUNC_W    = 3;
  localparam int SIZE_W    = 32;
  localparam int ADDR_W    = 48;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 48;

  // Offsets never exceed the pool size
  localparam int OFS_W   = 32;
  localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC_OUT   = 3'd0,
    FUNC_PUSH_TEMP   = 3'd1,
    FUNC_POP_TEMP    = 3'd2,
    FUNC_RELEASE_OUT = 3'd3,
    FUNC_RESTORE_OUT = 3'd4
  } func_t;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_OOM     = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_RESTORE = 3'd4,
    ST_TEMPS   = 3'd5
  } status_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 4'd1;

  // Round a value up to the alignment; result is one bit wider
  function automatic logic [SIZE_W:0] align_up(input logic [SIZE_W-1:0] v);
    logic [SIZE_W:0] sum;
    sum = {1'b0, v} + (SIZE_W + 1)'(ALIGNMENT - 1);
    return sum & ~((SIZE_W + 1)'(ALIGNMENT - 1));
  endfunction

endpackage

### rtl/core/deaa_if.sv
// Valid/ready channel interfaces for allocator requests and responses.
interface deaa_req_if;
  logic                            valid;
  logic                            ready;
  logic [deaa_pkg::FUNC_W-1:0]     func;
  logic [deaa_pkg::SIZE_W-1:0]     size_bytes;

  modport source (output valid, output func, output size_bytes, input ready);
  modport sink   (input valid, input func, input size_bytes, output ready);
endinterface

interface deaa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [deaa_pkg::ADDR_W-1:0]     address;
  logic [deaa_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output address, output status, input ready);
  modport sink   (input valid, input address, input status, output ready);
endinterface

### rtl/core/double_ended_arena_allocator_top.sv
// Double-ended arena allocator: output space grows up, temp stack grows down.
// Path: a request transfer is captured in the input register, then goes through one pass
// of add/compare logic into the response register, from which the response transfers.
// Throughput: one request per cycle; the response register and input register
// advance together whenever the response is free or being taken.
// Reset: synchronous; pool size, base and offsets clear, temp stack empties.
module double_ended_arena_allocator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [deaa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [deaa_pkg::CFG_W-1:0]       cfg_data,
  deaa_req_if.sink                         req,
  deaa_rsp_if.source                       rsp
);

  // Configuration and allocator state
  logic [deaa_pkg::SIZE_W-1:0]  pool_size;
  logic [deaa_pkg::ADDR_W-1:0]  base_address;
  logic [deaa_pkg::OFS_W-1:0]   output_offset;
  logic [deaa_pkg::OFS_W-1:0]   temp_offset;
  logic [deaa_pkg::COUNT_W-1:0] stack_count;
  logic [deaa_pkg::OFS_W-1:0]   temp_size_stack [deaa_pkg::STACK_DEPTH];

  // Input register
  logic                         in_vld;
  logic [deaa_pkg::FUNC_W-1:0]  in_func;
  logic [deaa_pkg::SIZE_W-1:0]  in_size;

  // Response register
  logic                         out_vld;
  logic [deaa_pkg::ADDR_W-1:0]  out_address;
  logic [deaa_pkg::STATUS_W-1:0] out_status;

  // Next values
  logic [deaa_pkg::OFS_W-1:0]    output_offset_next;
  logic [deaa_pkg::OFS_W-1:0]    temp_offset_next;
  logic [deaa_pkg::COUNT_W-1:0]  stack_count_next;
  logic                          push_we;
  logic [deaa_pkg::ADDR_W-1:0]   address_next;
  logic [deaa_pkg::STATUS_W-1:0] status_next;

  // Datapath terms
  logic                          advance;
  logic [deaa_pkg::SIZE_W:0]     out_aligned;
  logic [deaa_pkg::SIZE_W+1:0]   alloc_end;
  logic [deaa_pkg::SIZE_W:0]     push_rounded;
  logic [deaa_pkg::SIZE_W+1:0]   push_limit;
  logic [deaa_pkg::OFS_W-1:0]    push_offset;
  logic                          stack_full;
  logic                          stack_empty;
  logic [deaa_pkg::IDX_W-1:0]    wr_idx;
  logic [deaa_pkg::IDX_W-1:0]    rd_idx;
  logic [deaa_pkg::COUNT_W-1:0]  count_dec;

  // Handshake: the pipeline moves when the response slot is free or drains
  assign advance   = in_vld && (!out_vld || rsp.ready);
  assign req.ready = !in_vld || advance;

  assign rsp.valid   = out_vld;
  assign rsp.address = out_address;
  assign rsp.status  = out_status;

  // Shared arithmetic
  assign out_aligned  = deaa_pkg::align_up(output_offset);
  assign alloc_end    = {1'b0, out_aligned} + (deaa_pkg::SIZE_W + 2)'(in_size);
  assign push_rounded = deaa_pkg::align_up(in_size);
  assign push_limit   = (deaa_pkg::SIZE_W + 2)'(output_offset)
                      + (deaa_pkg::SIZE_W + 2)'(push_rounded);
  assign push_offset  = temp_offset - push_rounded[deaa_pkg::OFS_W-1:0];
  assign stack_full   = stack_count >= deaa_pkg::COUNT_W'(deaa_pkg::STACK_DEPTH);
  assign stack_empty  = stack_count == '0;
  assign count_dec    = stack_count - deaa_pkg::COUNT_W'(1);
  assign wr_idx       = stack_count[deaa_pkg::IDX_W-1:0];
  assign rd_idx       = count_dec[deaa_pkg::IDX_W-1:0];

  // Operation decode
  always_comb begin
    output_offset_next = output_offset;
    temp_offset_next   = temp_offset;
    stack_count_next   = stack_count;
    push_we            = 1'b0;
    address_next       = '0;
    status_next        = deaa_pkg::ST_OK;
    unique case (in_func)
      deaa_pkg::FUNC_ALLOC_OUT: begin
        if (alloc_end >= (deaa_pkg::SIZE_W + 2)'(temp_offset)) begin
          status_next = deaa_pkg::ST_OOM;
        end else begin
          output_offset_next = alloc_end[deaa_pkg::OFS_W-1:0];
          address_next = base_address + deaa_pkg::ADDR_W'(out_aligned);
        end
      end
      deaa_pkg::FUNC_PUSH_TEMP: begin
        if (stack_full) begin
          status_next = deaa_pkg::ST_FULL;
        end else if ((deaa_pkg::SIZE_W + 2)'(temp_offset) <= push_limit) begin
          status_next = deaa_pkg::ST_OOM;
        end else begin
          temp_offset_next = push_offset;
          stack_count_next = stack_count + deaa_pkg::COUNT_W'(1);
          push_we          = 1'b1;
          address_next     = base_address + deaa_pkg::ADDR_W'(push_offset);
        end
      end
      deaa_pkg::FUNC_POP_TEMP: begin
        if (stack_empty) begin
          status_next = deaa_pkg::ST_EMPTY;
        end else begin
          stack_count_next = count_dec;
          temp_offset_next = temp_offset + temp_size_stack[rd_idx];
        end
      end
      deaa_pkg::FUNC_RELEASE_OUT: begin
        if (!stack_empty) begin
          status_next = deaa_pkg::ST_TEMPS;
        end else begin
          output_offset_next = '0;
        end
      end
      deaa_pkg::FUNC_RESTORE_OUT: begin
        if (in_size > pool_size) begin
          status_next = deaa_pkg::ST_RESTORE;
        end else begin
          output_offset_next = in_size;
        end
      end
      default: begin
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_func <= req.func;
      in_size <= req.size_bytes;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_address <= address_next;
      out_status  <= status_next;
    end
  end

  // Allocator state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size     <= '0;
      base_address  <= '0;
      output_offset <= '0;
      temp_offset   <= '0;
      stack_count   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        deaa_pkg::REG_POOL_SIZE: begin
          pool_size     <= cfg_data[deaa_pkg::SIZE_W-1:0];
          output_offset <= '0;
          temp_offset   <= cfg_data[deaa_pkg::OFS_W-1:0];
          stack_count   <= '0;
        end
        deaa_pkg::REG_BASE_ADDRESS: begin
          base_address <= cfg_data[deaa_pkg::ADDR_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      output_offset <= output_offset_next;
      temp_offset   <= temp_offset_next;
      stack_count   <= stack_count_next;
    end
  end

  // Temp size stack, written on a successful push
  always_ff @(posedge clk) begin
    if (advance && push_we) begin
      temp_size_stack[wr_idx] <= push_rounded[deaa_pkg::OFS_W-1:0];
    end
  end

endmodule

### dv/testbench.sv
// Self-checking testbench for the double-ended arena allocator top level.
module testbench;

  // Unused request codes, and run limits
  localparam logic [deaa_pkg::FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [deaa_pkg::FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;
  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 100000;
  localparam int REPORT_MAX  = 10;

  typedef enum int {MOOD_FILL, MOOD_DRAIN, MOOD_MIXED} mood_t;

  typedef struct packed {
    logic [deaa_pkg::ADDR_W-1:0] address;
    deaa_pkg::status_t           status;
  } grant_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [deaa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [deaa_pkg::CFG_W-1:0]     cfg_data;

  deaa_req_if req_ch();
  deaa_rsp_if rsp_ch();

  double_ended_arena_allocator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Arena state as the block should hold it
  logic [63:0] pool_bytes;
  logic [63:0] base_addr;
  logic [63:0] out_ofs;
  logic [63:0] tmp_ofs;
  logic [63:0] temp_sizes [deaa_pkg::STACK_DEPTH];
  int          temp_depth;

  grant_t grants_due [$];
  int     mismatches;
  int     cycle_count;
  int     src_idle_pct;
  int     sink_idle_pct;

  function automatic logic [63:0] align_offset(input logic [63:0] v);
    logic [63:0] rem;
    rem = v % deaa_pkg::ALIGNMENT;
    return (rem == 0) ? v : v + (deaa_pkg::ALIGNMENT - rem);
  endfunction

  function automatic void apply_register(input logic [deaa_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [deaa_pkg::CFG_W-1:0] data);
    if (idx == deaa_pkg::REG_POOL_SIZE) begin
      pool_bytes = 64'(data[deaa_pkg::SIZE_W-1:0]);
      out_ofs    = '0;
      tmp_ofs    = pool_bytes;
      temp_depth = 0;
    end else if (idx == deaa_pkg::REG_BASE_ADDRESS) begin
      base_addr = 64'(data[deaa_pkg::ADDR_W-1:0]);
    end
  endfunction

  // Updates the arena state for one request and returns its grant
  function automatic grant_t arena_apply(input logic [deaa_pkg::FUNC_W-1:0] code,
                                         input logic [deaa_pkg::SIZE_W-1:0] size);
    grant_t      res;
    logic [63:0] region_start;
    logic [63:0] region_end;
    logic [63:0] rounded;
    logic [63:0] sum;
    res.address = '0;
    res.status  = deaa_pkg::ST_OK;
    case (code)
      deaa_pkg::FUNC_ALLOC_OUT: begin
        region_start = align_offset(out_ofs);
        region_end   = region_start + 64'(size);
        if (region_end >= tmp_ofs) begin
          res.status = deaa_pkg::ST_OOM;
        end else begin
          out_ofs     = region_end;
          sum         = base_addr + region_start;
          res.address = sum[deaa_pkg::ADDR_W-1:0];
        end
      end
      deaa_pkg::FUNC_PUSH_TEMP: begin
        rounded = align_offset({32'd0, size});
        if (temp_depth >= deaa_pkg::STACK_DEPTH) begin
          res.status = deaa_pkg::ST_FULL;
        end else if (tmp_ofs <= out_ofs + rounded) begin
          res.status = deaa_pkg::ST_OOM;
        end else begin
          tmp_ofs                = tmp_ofs - rounded;
          temp_sizes[temp_depth] = rounded;
          temp_depth++;
          sum         = base_addr + tmp_ofs;
          res.address = sum[deaa_pkg::ADDR_W-1:0];
        end
      end
      deaa_pkg::FUNC_POP_TEMP: begin
        if (temp_depth == 0) begin
          res.status = deaa_pkg::ST_EMPTY;
        end else begin
          temp_depth--;
          tmp_ofs = tmp_ofs + temp_sizes[temp_depth];
        end
      end
      deaa_pkg::FUNC_RELEASE_OUT: begin
        if (temp_depth != 0) res.status = deaa_pkg::ST_TEMPS;
        else out_ofs = '0;
      end
      deaa_pkg::FUNC_RESTORE_OUT: begin
        if (64'(size) > pool_bytes) res.status = deaa_pkg::ST_RESTORE;
        else out_ofs = 64'(size);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Response checker
  always @(posedge clk) begin
    grant_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (grants_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected response: address %h status %0d",
                   rsp_ch.address, rsp_ch.status);
      end else begin
        want = grants_due.pop_front();
        if (rsp_ch.address !== want.address || rsp_ch.status !== want.status) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: expected address %h status %0d, got address %h status %0d",
                     want.address, want.status, rsp_ch.address, rsp_ch.status);
        end
      end
    end
  end

  // Response stalls
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Register write; called and returns at a falling edge
  task automatic write_reg(input logic [deaa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [deaa_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One request transfer, with random gaps ahead of it
  task automatic send_request(input logic [deaa_pkg::FUNC_W-1:0] code,
                              input logic [deaa_pkg::SIZE_W-1:0] size);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= code;
    req_ch.size_bytes <= size;
    do @(posedge clk); while (!req_ch.ready);
    grants_due.insert(grants_due.size(), arena_apply(code, size));
    @(negedge clk);
  endtask

  // Stop sending and wait until every response is back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_pool(input logic [deaa_pkg::SIZE_W-1:0] pool);
    logic [deaa_pkg::CFG_W-deaa_pkg::SIZE_W-1:0] junk;
    junk = (deaa_pkg::CFG_W - deaa_pkg::SIZE_W)'($urandom());
    write_reg(deaa_pkg::REG_POOL_SIZE, {junk, pool});
  endtask

  // Random request shaped by the current burst mood
  task automatic send_random_request(input mood_t mood);
    deaa_pkg::func_t             order [5];
    int                          cuts [5];
    int                          pick;
    int                          sel;
    logic [deaa_pkg::FUNC_W-1:0] code;
    logic [deaa_pkg::SIZE_W-1:0] size;
    logic [63:0]                 gap;
    logic [63:0]                 span;
    order = '{deaa_pkg::FUNC_ALLOC_OUT, deaa_pkg::FUNC_PUSH_TEMP, deaa_pkg::FUNC_POP_TEMP,
              deaa_pkg::FUNC_RELEASE_OUT, deaa_pkg::FUNC_RESTORE_OUT};
    case (mood)
      MOOD_FILL:  cuts = '{30, 75, 85, 90, 95};
      MOOD_DRAIN: cuts = '{10, 15, 65, 80, 92};
      default:    cuts = '{28, 50, 70, 80, 92};
    endcase
    pick = $urandom_range(99);
    code = deaa_pkg::FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
    for (int i = 4; i >= 0; i--)
      if (pick < cuts[i]) code = order[i];
    sel  = $urandom_range(15);
    span = pool_bytes / 24 + 200;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    // Room left between the aligned output end and the temp area
    gap = (tmp_ofs > align_offset(out_ofs)) ? tmp_ofs - align_offset(out_ofs) : '0;
    if (code == deaa_pkg::FUNC_RESTORE_OUT)
      size = (sel == 0) ? $urandom()
                        : $urandom_range(0, pool_bytes[deaa_pkg::SIZE_W-1:0]);
    else if (sel == 0)
      size = $urandom();
    else if (sel == 1)
      size = gap[deaa_pkg::SIZE_W-1:0] - $urandom_range(0, 1);
    else
      size = $urandom_range(0, span[deaa_pkg::SIZE_W-1:0]);
    send_request(code, size);
  endtask

  task automatic run_segment(input int count, input logic [deaa_pkg::SIZE_W-1:0] pool,
                             input logic [deaa_pkg::ADDR_W-1:0] base, input bit new_pool);
    mood_t mood;
    settle();
    write_reg(deaa_pkg::REG_BASE_ADDRESS, base);
    if (new_pool) write_pool(pool);
    mood = MOOD_MIXED;
    for (int i = 0; i < count; i++) begin
      if (i % 8 == 0) mood = mood_t'($urandom_range(MOOD_MIXED));
      send_random_request(mood);
    end
  endtask

  // Zero pool after reset: out-of-room, empty-stack and restore failures, plus release and a spare code
  task automatic test_empty_pool();
    send_request(deaa_pkg::FUNC_ALLOC_OUT, '0);
    send_request(deaa_pkg::FUNC_PUSH_TEMP, '0);
    send_request(deaa_pkg::FUNC_POP_TEMP, '0);
    send_request(deaa_pkg::FUNC_RELEASE_OUT, '0);
    send_request(deaa_pkg::FUNC_RESTORE_OUT, '0);
    send_request(deaa_pkg::FUNC_RESTORE_OUT, 32'd1);
    send_request(FUNC_SPARE_LAST, '1);
    settle();
    // Writes to indexes past the last register must be ignored
    write_reg(deaa_pkg::CFG_IDX_W'($urandom_range(deaa_pkg::REG_BASE_ADDRESS + 1,
                                                  2 ** deaa_pkg::CFG_IDX_W - 1)),
              {16'($urandom()), $urandom()});
  endtask

  // Largest aligned pool, base near the top so addresses wrap, full temp stack
  task automatic test_stack_limits();
    settle();
    write_reg(deaa_pkg::REG_BASE_ADDRESS, 48'hFFFF_FFFF_FF80);
    write_pool(32'hFFFF_FF80);
    send_request(deaa_pkg::FUNC_ALLOC_OUT, '1);
    send_request(deaa_pkg::FUNC_PUSH_TEMP, '1);
    send_request(deaa_pkg::FUNC_ALLOC_OUT, 32'd1);
    send_request(deaa_pkg::FUNC_ALLOC_OUT, '0);
    for (int i = 0; i <= deaa_pkg::STACK_DEPTH; i++)
      send_request(deaa_pkg::FUNC_PUSH_TEMP, deaa_pkg::SIZE_W'(i * 200 + 1));
    send_request(deaa_pkg::FUNC_RELEASE_OUT, '0);
  endtask

  task automatic test_random_slow_sink();
    src_idle_pct  = 13;
    sink_idle_pct = 60;
    run_segment(90, 32'd4096, {16'($urandom_range(0, 16'hFFFF)), 32'h0}, 1'b1);
    run_segment(90, '1, '0, 1'b1);
    run_segment(90, $urandom_range(1, 64) * deaa_pkg::ALIGNMENT, '1, 1'b1);
  endtask

  task automatic test_random_slow_source();
    src_idle_pct  = 60;
    sink_idle_pct = 13;
    run_segment(60, '0, {$urandom(), 16'h0}, 1'b1);
    run_segment(100, 32'hFFFF_FF80, {$urandom(), 16'hFF80}, 1'b1);
    run_segment(100, $urandom_range(0, 65535), {16'($urandom()), $urandom()}, 1'b1);
  endtask

  task automatic test_random_full_rate();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_segment(100, $urandom_range(8, 256) * deaa_pkg::ALIGNMENT, {$urandom(), 16'h0},
                1'b1);
    // Base change alone keeps the arena contents
    run_segment(100, '0, {16'($urandom()), $urandom()}, 1'b0);
    run_segment(80, $urandom(), '0, 1'b1);
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.func       = '0;
    req_ch.size_bytes = '0;
    rsp_ch.ready      = 1'b0;
    mismatches        = 0;
    cycle_count       = 0;
    src_idle_pct      = 13;
    sink_idle_pct     = 60;
    pool_bytes        = '0;
    base_addr         = '0;
    out_ofs           = '0;
    tmp_ofs           = '0;
    temp_depth        = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_pool();
    test_stack_limits();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_full_rate();
    settle();

    if (mismatches == 0 && grants_due.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### double_ended_arena_allocator_top.f
rtl/core/deaa_pkg.sv
rtl/core/deaa_if.sv
rtl/core/double_ended_arena_allocator_top.sv
dv/testbench.sv
